/* design/qrs_pkg.sv */
// qrs_pkg: shared types and constants of the quadratic root solver
// no dependencies; used by quadratic_root_solver_core and its testbench
package qrs_pkg;

  localparam int COEF_BITS     = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS      = 48;

  localparam logic [1:0] KIND_ONE   = 2'd0;
  localparam logic [1:0] KIND_TWO   = 2'd1;
  localparam logic [1:0] KIND_CPLX  = 2'd2;
  localparam logic [1:0] KIND_AZERO = 2'd3;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                 root_kind;
    logic signed [OUT_BITS-1:0] first_value;
    logic signed [OUT_BITS-1:0] second_value;
  } qrs_out_t;

  // travels beside the square root cells
  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic [1:0]                  kind;
  } qrs_sq_side_t;

  // travels beside the divider cells
  typedef struct packed {
    logic [1:0] kind;
    logic       neg1;
    logic       neg2;
  } qrs_dv_side_t;

endpackage

/* design/qrs_sqrt_cell.sv */
// qrs_sqrt_cell: one radix-2 step of a restoring square root, registered
// depends on nothing; chained by quadratic_root_solver_core
module qrs_sqrt_cell #(
  parameter int SW     = 33,
  parameter int SIDE_W = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              src_valid,
  input  logic [2*SW-1:0]   src_rad,
  input  logic [SW:0]       src_rem,
  input  logic [SW-1:0]     src_root,
  input  logic [SIDE_W-1:0] src_side,
  output logic              valid,
  output logic [2*SW-1:0]   rad,
  output logic [SW:0]       rem,
  output logic [SW-1:0]     root,
  output logic [SIDE_W-1:0] side
);

  logic [SW+2:0]   rem_sh;
  logic [SW+2:0]   trial;
  logic [SW+2:0]   rem_sub;
  logic            ge;
  logic [SW:0]     rem_next;
  logic [SW-1:0]   root_next;
  logic [2*SW-1:0] rad_next;

  always_comb begin
    rem_sh    = {src_rem, src_rad[2*SW-1 -: 2]};
    trial     = {1'b0, src_root, 2'b01};
    ge        = rem_sh >= trial;
    rem_sub   = rem_sh - trial;
    rem_next  = ge ? rem_sub[SW:0] : rem_sh[SW:0];
    root_next = {src_root[SW-2:0], ge};
    rad_next  = {src_rad[2*SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
      side <= src_side;
    end
  end

endmodule

/* design/qrs_div_cell.sv */
// qrs_div_cell: one restoring division step for two dividends sharing a divisor
// depends on nothing; chained by quadratic_root_solver_core
module qrs_div_cell #(
  parameter int QW     = 34,
  parameter int DW     = 17,
  parameter int SIDE_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                src_valid,
  input  logic [1:0][QW-1:0]  src_dvd,
  input  logic [1:0][DW-1:0]  src_rem,
  input  logic [1:0][QW-1:0]  src_quo,
  input  logic [DW-1:0]       src_den,
  input  logic [SIDE_W-1:0]   src_side,
  output logic                valid,
  output logic [1:0][QW-1:0]  dvd,
  output logic [1:0][DW-1:0]  rem,
  output logic [1:0][QW-1:0]  quo,
  output logic [DW-1:0]       den,
  output logic [SIDE_W-1:0]   side
);

  logic [1:0][DW:0]    rem_sh;
  logic [1:0][DW:0]    rem_sub;
  logic [1:0]          ge;
  logic [1:0][DW-1:0]  rem_next;
  logic [1:0][QW-1:0]  quo_next;
  logic [1:0][QW-1:0]  dvd_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]   = {src_rem[l], src_dvd[l][QW-1]};
      ge[l]       = rem_sh[l] >= {1'b0, src_den};
      rem_sub[l]  = rem_sh[l] - {1'b0, src_den};
      rem_next[l] = ge[l] ? rem_sub[l][DW-1:0] : rem_sh[l][DW-1:0];
      quo_next[l] = {src_quo[l][QW-2:0], ge[l]};
      dvd_next[l] = {src_dvd[l][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd  <= dvd_next;
      rem  <= rem_next;
      quo  <= quo_next;
      den  <= src_den;
      side <= src_side;
    end
  end

endmodule

/* design/quadratic_root_solver_core.sv */
// quadratic_root_solver_core: top level of the quadratic root solver
// depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell
//
// Usage:
//   req channel: req_valid / req_stall / req carry one coefficient triple a, b, c
//   rsp channel: rsp_valid / rsp_stall / rsp carry root kind and two Q.FRAC_BITS values
//   a beat moves on a rising edge with valid high and stall low
// Pipeline: three front stages, one square root cell per root bit, two
//   numerator stages, one divider cell per quotient bit, then the output
//   register
// Throughput: one beat per cycle while the skid register is empty; all cells step together while en is high
// Stall: a skid register behind the output catches the beat that arrives
//   while rsp_stall holds; while it is full the whole chain freezes and
//   req_stall is high, and it drains as soon as the output is taken
// Reset: synchronous rst empties the chain, output and skid; req_stall is low
//   right after reset
module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  qrs_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output qrs_out_t rsp
);

  localparam int C       = COEF_BITS;
  localparam int SW      = C + 1 + FRAC_BITS;   // root bits
  localparam int RADW    = 2 * SW;
  localparam int DSW     = 2 * C + 2;
  localparam int NW      = C + FRAC_BITS + 3;   // signed numerator
  localparam int QW      = NW - 1;              // numerator magnitude, quotient
  localparam int DW      = C + 1;               // divisor 2|a|
  localparam int EW      = QW + OUT_BITS;
  localparam int SQ_SW   = $bits(qrs_sq_side_t);
  localparam int DV_SW   = $bits(qrs_dv_side_t);
  localparam logic [EW-1:0] POS_LIM = (EW'(1) << (OUT_BITS - 1)) - EW'(1);
  localparam logic [EW-1:0] NEG_LIM = EW'(1) << (OUT_BITS - 1);

  function automatic logic [C-1:0] coef_mag(input logic signed [C-1:0] v);
    logic signed [C-1:0] n;
    n = -v;
    return v[C-1] ? C'(n) : C'(v);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_val(input logic [QW-1:0] q,
                                                         input logic neg);
    logic [EW-1:0]       qx;
    logic [EW-1:0]       lim;
    logic [OUT_BITS-1:0] m;
    qx  = EW'(q);
    lim = neg ? NEG_LIM : POS_LIM;
    m   = (qx > lim) ? lim[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
    return neg ? $signed(OUT_BITS'(0) - m) : $signed(m);
  endfunction

  logic en;
  logic skid_valid;
  qrs_out_t skid;

  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  // front stage 0: input register
  logic    s0_valid;
  qrs_in_t s0_in;

  // front stage 1: products
  logic                s1_valid;
  logic signed [C-1:0] s1_a;
  logic signed [C-1:0] s1_b;
  logic [2*C-1:0]      s1_bb;
  logic [2*C-1:0]      s1_ac;
  logic                s1_opp;
  logic [C-1:0]        am0;
  logic [C-1:0]        bm0;
  logic [C-1:0]        cm0;

  // front stage 2: discriminant
  logic                s2_valid;
  logic [RADW-1:0]     s2_rad;
  qrs_sq_side_t        s2_side;
  logic [DSW-1:0]      bb_x;
  logic [DSW-1:0]      fac;
  logic [DSW-1:0]      d_sum;
  logic [DSW-1:0]      d_up;
  logic [DSW-1:0]      d_dn;
  logic [DSW-1:0]      dmag;
  logic                d_ge;
  logic [1:0]          kind1;

  always_comb begin
    am0 = coef_mag(s0_in.coef_a);
    bm0 = coef_mag(s0_in.coef_b);
    cm0 = coef_mag(s0_in.coef_c);
  end

  always_comb begin
    bb_x  = DSW'(s1_bb);
    fac   = {s1_ac, 2'b00};
    d_sum = bb_x + fac;
    d_up  = bb_x - fac;
    d_dn  = fac - bb_x;
    d_ge  = bb_x >= fac;
    if (s1_opp) begin
      dmag = d_sum;
    end else if (d_ge) begin
      dmag = d_up;
    end else begin
      dmag = d_dn;
    end
    if (s1_a == '0) begin
      kind1 = KIND_AZERO;
    end else if (s1_opp) begin
      kind1 = KIND_TWO;
    end else if (bb_x == fac) begin
      kind1 = KIND_ONE;
    end else if (d_ge) begin
      kind1 = KIND_TWO;
    end else begin
      kind1 = KIND_CPLX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_in          <= req;
      s1_a           <= s0_in.coef_a;
      s1_b           <= s0_in.coef_b;
      s1_bb          <= bm0 * bm0;
      s1_ac          <= am0 * cm0;
      s1_opp         <= (s0_in.coef_a[C-1] ^ s0_in.coef_c[C-1]) &&
                        (s0_in.coef_a != '0) && (s0_in.coef_c != '0);
      s2_rad         <= RADW'(dmag[2*C:0]) << (2 * FRAC_BITS);
      s2_side.coef_a <= s1_a;
      s2_side.coef_b <= s1_b;
      s2_side.kind   <= kind1;
    end
  end

  // square root chain
  logic             sq_valid [0:SW];
  logic [RADW-1:0]  sq_rad   [0:SW];
  logic [SW:0]      sq_rem   [0:SW];
  logic [SW-1:0]    sq_root  [0:SW];
  logic [SQ_SW-1:0] sq_side  [0:SW];

  assign sq_valid[0] = s2_valid;
  assign sq_rad[0]   = s2_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = s2_side;

  for (genvar i = 0; i < SW; i++) begin : g_sq
    qrs_sqrt_cell #(
      .SW     (SW),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (sq_valid[i]),
      .src_rad   (sq_rad[i]),
      .src_rem   (sq_rem[i]),
      .src_root  (sq_root[i]),
      .src_side  (sq_side[i]),
      .valid     (sq_valid[i+1]),
      .rad       (sq_rad[i+1]),
      .rem       (sq_rem[i+1]),
      .root      (sq_root[i+1]),
      .side      (sq_side[i+1])
    );
  end

  // numerator stages
  qrs_sq_side_t         sqe;
  logic signed [NW-1:0] b_x;
  logic signed [NW-1:0] nb;
  logic signed [NW-1:0] s_x;
  logic signed [NW-1:0] num1;
  logic signed [NW-1:0] num2;

  logic                 s3_valid;
  logic signed [NW-1:0] s3_num1;
  logic signed [NW-1:0] s3_num2;
  logic signed [C-1:0]  s3_a;
  logic [1:0]           s3_kind;

  logic                 s4_valid;
  logic [1:0][QW-1:0]   s4_dvd;
  logic [DW-1:0]        s4_den;
  qrs_dv_side_t         s4_side;
  logic signed [NW-1:0] n1_neg;
  logic signed [NW-1:0] n2_neg;

  always_comb begin
    sqe  = qrs_sq_side_t'(sq_side[SW]);
    b_x  = NW'(sqe.coef_b);
    nb   = -(b_x <<< FRAC_BITS);
    s_x  = $signed(NW'(sq_root[SW]));
    num1 = (sqe.kind == KIND_TWO) ? nb + s_x : nb;
    case (sqe.kind)
      KIND_TWO:  num2 = nb - s_x;
      KIND_CPLX: num2 = s_x;
      default:   num2 = nb;
    endcase
    n1_neg = -s3_num1;
    n2_neg = -s3_num2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sq_valid[SW];
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num1      <= num1;
      s3_num2      <= num2;
      s3_a         <= sqe.coef_a;
      s3_kind      <= sqe.kind;
      s4_dvd[0]    <= s3_num1[NW-1] ? n1_neg[QW-1:0] : s3_num1[QW-1:0];
      s4_dvd[1]    <= s3_num2[NW-1] ? n2_neg[QW-1:0] : s3_num2[QW-1:0];
      s4_den       <= {coef_mag(s3_a), 1'b0};
      s4_side.kind <= s3_kind;
      s4_side.neg1 <= s3_num1[NW-1] ^ s3_a[C-1];
      s4_side.neg2 <= s3_num2[NW-1] ^ s3_a[C-1];
    end
  end

  // divider chain
  logic               dv_valid [0:QW];
  logic [1:0][QW-1:0] dv_dvd   [0:QW];
  logic [1:0][DW-1:0] dv_rem   [0:QW];
  logic [1:0][QW-1:0] dv_quo   [0:QW];
  logic [DW-1:0]      dv_den   [0:QW];
  logic [DV_SW-1:0]   dv_side  [0:QW];

  assign dv_valid[0] = s4_valid;
  assign dv_dvd[0]   = s4_dvd;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = '0;
  assign dv_den[0]   = s4_den;
  assign dv_side[0]  = s4_side;

  for (genvar i = 0; i < QW; i++) begin : g_dv
    qrs_div_cell #(
      .QW     (QW),
      .DW     (DW),
      .SIDE_W (DV_SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (dv_valid[i]),
      .src_dvd   (dv_dvd[i]),
      .src_rem   (dv_rem[i]),
      .src_quo   (dv_quo[i]),
      .src_den   (dv_den[i]),
      .src_side  (dv_side[i]),
      .valid     (dv_valid[i+1]),
      .dvd       (dv_dvd[i+1]),
      .rem       (dv_rem[i+1]),
      .quo       (dv_quo[i+1]),
      .den       (dv_den[i+1]),
      .side      (dv_side[i+1])
    );
  end

  // result formatting
  qrs_dv_side_t dve;
  qrs_out_t     fin;
  logic         take;

  always_comb begin
    dve           = qrs_dv_side_t'(dv_side[QW]);
    fin.root_kind = dve.kind;
    if (dve.kind == KIND_AZERO) begin
      fin.first_value  = '0;
      fin.second_value = '0;
    end else begin
      fin.first_value  = sat_val(dv_quo[QW][0], dve.neg1);
      fin.second_value = sat_val(dv_quo[QW][1], dve.neg2);
    end
  end

  assign take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (dv_valid[QW]) begin
      if (rsp_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        rsp <= skid;
      end
    end else if (dv_valid[QW]) begin
      if (rsp_valid && !take) begin
        skid <= fin;
      end else begin
        rsp <= fin;
      end
    end
  end

endmodule

/* tb/sv/quadratic_root_solver_core_tb.sv */
`timescale 1ns / 100ps
// quadratic_root_solver_core_tb: self-checking bench for the quadratic root solver
// depends on qrs_pkg and quadratic_root_solver_core; predicts every response locally
module quadratic_root_solver_core_tb;
  import qrs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 2 * COEF_BITS + 2 * FRAC + 9;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  qrs_in_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  qrs_out_t rsp;

  qrs_out_t roots_due[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  bit idle_on = 1'b1;
  longint cycles = 0;

  quadratic_root_solver_core u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycles, roots_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // floor of sqrt(n), n below 2^96
  function automatic logic [63:0] isqrt96(logic [95:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if ({64'd0, t} * {64'd0, t} <= {32'd0, n}) r = t;
    end
    return r;
  endfunction

  // trunc(num / 2a), saturated to the output width
  function automatic logic [OUT_BITS-1:0] half_quot(longint num, longint a);
    logic [63:0] q;
    logic [63:0] lim;
    bit neg;
    lim = 64'd1 << (OUT_BITS - 1);
    q = (num < 0 ? -num : num) / (2 * (a < 0 ? -a : a));
    neg = (num < 0) != (a < 0);
    if (!neg) return (q > lim - 1) ? lim - 1 : q;
    if (q > lim) q = lim;
    return -q;
  endfunction

  function automatic qrs_out_t solve_roots(qrs_in_t c_in);
    qrs_out_t o;
    longint a, b, c, nb, disc, s;
    a = c_in.coef_a;
    b = c_in.coef_b;
    c = c_in.coef_c;
    o = '0;
    if (a == 0) begin
      o.root_kind = KIND_AZERO;
      return o;
    end
    disc = b * b - 4 * a * c;
    s = isqrt96({32'd0, (disc < 0 ? -disc : disc)} << (2 * FRAC));
    nb = -b * (longint'(1) << FRAC);
    if (disc == 0) begin
      o.root_kind = KIND_ONE;
      o.first_value = half_quot(nb, a);
      o.second_value = o.first_value;
    end else if (disc > 0) begin
      o.root_kind = KIND_TWO;
      o.first_value = half_quot(nb + s, a);
      o.second_value = half_quot(nb - s, a);
    end else begin
      o.root_kind = KIND_CPLX;
      o.first_value = half_quot(nb, a);
      o.second_value = half_quot(s, a);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
  endtask

  // response checker and receiver-side stall
  initial begin
    int hold;
    qrs_out_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (roots_due.size() == 0) report_mismatch("unexpected beat", rsp.root_kind, 0);
        else begin
          want = roots_due.pop_front();
          if (rsp.root_kind != want.root_kind)
            report_mismatch("root_kind", rsp.root_kind, want.root_kind);
          if (rsp.first_value != want.first_value)
            report_mismatch("first_value", rsp.first_value, want.first_value);
          if (rsp.second_value != want.second_value)
            report_mismatch("second_value", rsp.second_value, want.second_value);
        end
        beats_seen++;
      end
      if (hold > 0) hold--;
      else if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 14);
      rsp_stall <= (hold > 0);
    end
  end

  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    qrs_in_t t;
    qrs_out_t p;
    int gap;
    t.coef_a = a;
    t.coef_b = b;
    t.coef_c = c;
    req <= t;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    p = solve_roots(t);
    roots_due.push_back(p);
    kind_count[p.root_kind]++;
    beats_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    send_coefs(16'd0, 16'd5, 16'd3);        // leading coefficient zero
    send_coefs(16'd1, -16'sd2, 16'd1);      // double root
    send_coefs(16'd1, 16'd0, -16'sd4);      // two real
    send_coefs(16'd1, 16'd0, 16'd4);        // complex pair
    send_coefs(-16'sd3, 16'd7, 16'd2);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        send_coefs(ext[i], ext[j], ext[(i + j) % 5]);
  endtask

  task automatic test_random(int n);
    logic [15:0] a, b, c, r;
    for (int i = 0; i < n; i++) begin
      a = $urandom;
      b = $urandom;
      c = $urandom;
      case ($urandom_range(0, 5))
        0: a = $urandom_range(0, 7) - 3;
        1: begin  // perfect square: a(x-r)^2
          a = $urandom_range(0, 15) - 8;
          r = $urandom_range(0, 20) - 10;
          b = -2 * a * r;
          c = a * r * r;
        end
        2: begin
          b = $urandom_range(0, 63) - 32;
          c = $urandom_range(0, 63) - 32;
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(900);
    idle_on = 1'b0;
    test_random(300);
    req_valid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d coefficient triples, checked %0d responses", beats_sent, beats_seen);
    $display("kinds one/two/complex/a-zero: %0d %0d %0d %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
